/* hdl/bic_pkg.sv */
// Shared types and constants for the binned interval coverage core.
// Used by the divider, controller, datapath and top level.
package bic_pkg;

  localparam int NUM_CHROMS_DEF     = 32;
  localparam int BINS_PER_CHROM_DEF = 4096;
  localparam int CFG_IDX_W          = 1;

  // 10^7 * 256: scale and 8 fraction bits folded into one factor
  localparam logic [31:0] NORM_MUL = 32'd2560000000;
  localparam logic [47:0] MAX48    = 48'hFFFF_FFFF_FFFF;

  localparam int DIV_N_W = 64;
  localparam int DIV_D_W = 32;

  typedef enum logic [1:0] {OP_SET, OP_ADD, OP_READ, OP_NONE} opcode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_UNKNOWN  = 3'd1,
    ST_END_OOB  = 3'd2,
    ST_DUP      = 3'd3,
    ST_TOO_MANY = 3'd4,
    ST_BAD_BIN  = 3'd5
  } status_t;

  typedef enum logic [0:0] {CFG_BIN_SIZE, CFG_NORM_EN} cfg_idx_t;

  typedef enum logic [1:0] {DSEL_LEN, DSEL_LAST, DSEL_LO, DSEL_NORM} div_sel_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_WLEN, S_LCHK, S_CLEAR, S_WLAST, S_ACHK, S_WLO,
    S_AINIT, S_WRD, S_WWR, S_RMUL, S_RCAP, S_NMUL, S_NSEL, S_WNORM,
    S_NDONE, S_FIN
  } state_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     st_set;
    status_t  st_code;
    logic     define_chrom;
    logic     clear_step;
    logic     qhi_cap;
    logic     walk_init;
    logic     walk_rd;
    logic     walk_wr;
    logic     rd_issue;
    logic     rd_capture;
    logic     norm_mul;
    logic     norm_raw;
    logic     norm_zero;
    logic     norm_div;
    logic     out_load;
  } bic_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    ch_ok;
    logic    ch_valid;
    logic    div_busy;
    logic    too_many;
    logic    end_oob;
    logic    empty;
    logic    bad_bin;
    logic    norm_en;
    logic    total_zero;
    logic    walk_last;
    logic    clear_last;
    logic    out_free;
  } bic_stat_t;

endpackage

/* hdl/bic_div.sv */
// Restoring divider, one quotient bit per cycle, 64-bit by 32-bit.
// Depends on bic_pkg for widths.
module bic_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bic_pkg::DIV_N_W-1:0] dividend,
  input  logic [bic_pkg::DIV_D_W-1:0] divisor,
  output logic                        busy,
  output logic [bic_pkg::DIV_N_W-1:0] quot,
  output logic [bic_pkg::DIV_D_W-1:0] rem
);
  import bic_pkg::*;

  localparam int CW = $clog2(DIV_N_W);

  logic [DIV_N_W-1:0] dq_r;
  logic [DIV_D_W-1:0] rem_r, d_r;
  logic [CW-1:0]      cnt_r;
  logic               busy_r;
  logic [DIV_D_W:0]   trial;
  logic               ge;

  assign trial = {rem_r, dq_r[DIV_N_W-1]};
  assign ge    = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(DIV_N_W - 1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      dq_r  <= {dq_r[DIV_N_W-2:0], ge};
      rem_r <= ge ? DIV_D_W'(trial - {1'b0, d_r}) : trial[DIV_D_W-1:0];
    end
  end

  assign busy = busy_r;
  assign quot = dq_r;
  assign rem  = rem_r;

endmodule

/* hdl/bic_ctrl.sv */
// Controller state machine: sequences decode, divisions, bin walk,
// clear sweep and readout. Depends on bic_pkg.
module bic_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bic_pkg::bic_stat_t stat,
  output bic_pkg::bic_cmd_t  cmd
);
  import bic_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        priority if (stat.op == OP_NONE || !stat.ch_ok) state_nxt = S_FIN;
        else if (stat.op == OP_SET) state_nxt = stat.ch_valid ? S_FIN : S_WLEN;
        else if (!stat.ch_valid) state_nxt = S_FIN;
        else if (stat.op == OP_ADD) state_nxt = S_WLAST;
        else state_nxt = stat.bad_bin ? S_FIN : S_RMUL;
      end
      S_WLEN:   if (!stat.div_busy) state_nxt = S_LCHK;
      S_LCHK:   state_nxt = stat.too_many ? S_FIN : S_CLEAR;
      S_CLEAR:  if (stat.clear_last) state_nxt = S_FIN;
      S_WLAST:  if (!stat.div_busy) state_nxt = S_ACHK;
      S_ACHK:   state_nxt = (stat.end_oob || stat.empty) ? S_FIN : S_WLO;
      S_WLO:    if (!stat.div_busy) state_nxt = S_AINIT;
      S_AINIT:  state_nxt = S_WRD;
      S_WRD:    state_nxt = S_WWR;
      S_WWR:    state_nxt = stat.walk_last ? S_FIN : S_WRD;
      S_RMUL:   state_nxt = S_RCAP;
      S_RCAP:   state_nxt = S_NMUL;
      S_NMUL:   state_nxt = S_NSEL;
      S_NSEL:   state_nxt = (!stat.norm_en || stat.total_zero) ? S_FIN : S_WNORM;
      S_WNORM:  if (!stat.div_busy) state_nxt = S_NDONE;
      S_NDONE:  state_nxt = S_FIN;
      S_FIN:    if (stat.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE:   cmd.load = in_valid;
      S_DECODE: begin
        priority if (stat.op == OP_NONE) begin
          cmd.st_set = 1'b0;
        end else if (!stat.ch_ok) begin
          cmd.st_set  = 1'b1;
          cmd.st_code = ST_UNKNOWN;
        end else if (stat.op == OP_SET) begin
          if (stat.ch_valid) begin
            cmd.st_set  = 1'b1;
            cmd.st_code = ST_DUP;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DSEL_LEN;
          end
        end else if (!stat.ch_valid) begin
          cmd.st_set  = 1'b1;
          cmd.st_code = ST_UNKNOWN;
        end else if (stat.op == OP_ADD) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_LAST;
        end else if (stat.bad_bin) begin
          cmd.st_set  = 1'b1;
          cmd.st_code = ST_BAD_BIN;
        end else begin
          cmd.rd_issue = 1'b1;
        end
      end
      S_LCHK: begin
        if (stat.too_many) begin
          cmd.st_set  = 1'b1;
          cmd.st_code = ST_TOO_MANY;
        end else begin
          cmd.define_chrom = 1'b1;
        end
      end
      S_CLEAR:  cmd.clear_step = 1'b1;
      S_ACHK: begin
        if (stat.end_oob) begin
          cmd.st_set  = 1'b1;
          cmd.st_code = ST_END_OOB;
        end else if (!stat.empty) begin
          cmd.qhi_cap   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_LO;
        end
      end
      S_AINIT:  cmd.walk_init  = 1'b1;
      S_WRD:    cmd.walk_rd    = 1'b1;
      S_WWR:    cmd.walk_wr    = 1'b1;
      S_RCAP:   cmd.rd_capture = 1'b1;
      S_NMUL:   cmd.norm_mul   = 1'b1;
      S_NSEL: begin
        if (!stat.norm_en) cmd.norm_raw = 1'b1;
        else if (stat.total_zero) cmd.norm_zero = 1'b1;
        else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_NORM;
        end
      end
      S_NDONE:  cmd.norm_div = 1'b1;
      S_FIN:    cmd.out_load = stat.out_free;
      default:  cmd.load = 1'b0;
    endcase
  end

endmodule

/* hdl/bic_datapath.sv */
// Datapath: config and chromosome tables, bin counter memory, divider,
// bin walk arithmetic, readout scaling and output register.
// Depends on bic_pkg and bic_div.
module bic_datapath #(
  parameter int NUM_CHROMS     = bic_pkg::NUM_CHROMS_DEF,
  parameter int BINS_PER_CHROM = bic_pkg::BINS_PER_CHROM_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bic_pkg::bic_cmd_t             cmd,
  output bic_pkg::bic_stat_t            stat,
  input  logic [1:0]                    in_opcode,
  input  logic [4:0]                    in_chrom_index,
  input  logic [31:0]                   in_first_base,
  input  logic [31:0]                   in_last_base,
  input  logic [31:0]                   in_chrom_length,
  input  logic [11:0]                   in_bin_index,
  input  logic                          cfg_we,
  input  logic [bic_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_status,
  output logic [31:0]                   out_position,
  output logic [31:0]                   out_coverage,
  output logic [47:0]                   out_normalized,
  output logic                          out_nonzero
);
  import bic_pkg::*;

  localparam int CHW       = (NUM_CHROMS > 1) ? $clog2(NUM_CHROMS) : 1;
  localparam int BW        = $clog2(BINS_PER_CHROM);
  localparam int NBW       = BW + 1;
  localparam int AW        = CHW + BW;
  localparam int MEM_DEPTH = NUM_CHROMS * (2 ** BW);

  opcode_t      op_r;
  logic [4:0]   ch_r;
  logic [31:0]  first_r, last_r, len_r;
  logic [11:0]  bi_r;
  logic [31:0]  bin_size_r;
  logic         norm_en_r;
  logic [31:0]  total_r;
  status_t      st_r;
  logic [31:0]  pos_r, cov_r;
  logic [47:0]  norm_r;

  logic [NUM_CHROMS-1:0] chv_r;
  logic [31:0]           chlen_r  [NUM_CHROMS];
  logic [NBW-1:0]        chbins_r [NUM_CHROMS];

  logic [31:0]    qhi_r;
  logic [BW-1:0]  b_r;
  logic [NBW-1:0] nb_r;
  logic [32:0]    bstart_r;
  logic [43:0]    p_r;
  logic [63:0]    prod_r;

  logic [31:0] mem [MEM_DEPTH];
  logic [31:0] rdata_r;

  logic        out_valid_r, out_nz_r;
  status_t     out_status_r;
  logic [31:0] out_pos_r, out_cov_r;
  logic [47:0] out_norm_r;

  logic [31:0]    bs;
  logic [CHW-1:0] chx;
  logic [31:0]    cur_len;
  logic [NBW-1:0] cur_bins;
  logic [32:0]    lo;
  logic [63:0]    dvd, quot;
  logic [31:0]    dvs, rem;
  logic           div_busy;
  logic [32:0]    nb_calc;
  logic [33:0]    bend;
  logic [32:0]    wa, we_end, amt;
  logic [33:0]    sum;
  logic [31:0]    wsat;
  logic [44:0]    p1;
  logic [31:0]    pos_calc;
  logic           mem_we, mem_re;
  logic [AW-1:0]  waddr, raddr;
  logic [31:0]    wdata;

  assign bs       = (bin_size_r == 32'd0) ? 32'd1 : bin_size_r;
  assign chx      = CHW'(ch_r);
  assign cur_len  = chlen_r[chx];
  assign cur_bins = chbins_r[chx];
  assign lo       = {1'b0, first_r} + 33'd1;

  always_comb begin
    unique case (cmd.div_sel)
      DSEL_LEN:  begin dvd = {32'd0, len_r};  dvs = bs;      end
      DSEL_LAST: begin dvd = {32'd0, last_r}; dvs = bs;      end
      DSEL_LO:   begin dvd = {31'd0, lo};     dvs = bs;      end
      DSEL_NORM: begin dvd = prod_r;          dvs = total_r; end
      default:   begin dvd = prod_r;          dvs = total_r; end
    endcase
  end

  bic_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .busy     (div_busy),
    .quot     (quot),
    .rem      (rem)
  );

  assign nb_calc = {1'b0, quot[31:0]} + 33'd1;

  // per-bin share of the interval
  assign bend   = {1'b0, bstart_r} + {2'b0, bs} - 34'd1;
  assign wa     = (lo > bstart_r) ? lo : bstart_r;
  assign we_end = ({2'b0, last_r} < bend) ? {1'b0, last_r} : bend[32:0];
  assign amt    = we_end - wa + 33'd1;
  assign sum    = {2'b0, rdata_r} + {1'b0, amt};
  assign wsat   = (sum > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];

  assign p1       = {1'b0, p_r} + 45'd1;
  assign pos_calc = (p1 > {13'd0, cur_len}) ? cur_len : p1[31:0];

  always_comb begin
    stat.op         = op_r;
    stat.ch_ok      = ({27'd0, ch_r} < 32'(NUM_CHROMS));
    stat.ch_valid   = chv_r[chx];
    stat.div_busy   = div_busy;
    stat.too_many   = nb_calc > 33'(BINS_PER_CHROM);
    stat.end_oob    = quot[31:0] >= 32'(cur_bins);
    stat.empty      = last_r <= first_r;
    stat.bad_bin    = 32'(bi_r) >= 32'(cur_bins);
    stat.norm_en    = norm_en_r;
    stat.total_zero = (total_r == 32'd0);
    stat.walk_last  = (32'(b_r) == qhi_r);
    stat.clear_last = (({1'b0, b_r} + NBW'(1)) == nb_r);
    stat.out_free   = !out_valid_r || !out_stall;
  end

  // bin counter memory
  assign mem_we = cmd.clear_step || cmd.walk_wr;
  assign mem_re = cmd.walk_rd || cmd.rd_issue;
  assign waddr  = {chx, b_r};
  assign raddr  = cmd.rd_issue ? {chx, BW'(bi_r)} : {chx, b_r};
  assign wdata  = cmd.clear_step ? 32'd0 : wsat;

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) rdata_r <= mem[raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_size_r  <= 32'd1;
      norm_en_r   <= 1'b1;
      total_r     <= '0;
      chv_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_BIN_SIZE: bin_size_r <= cfg_data;
          CFG_NORM_EN:  norm_en_r  <= cfg_data[0];
          default:      norm_en_r  <= norm_en_r;
        endcase
      end
      if (cmd.load && opcode_t'(in_opcode) == OP_ADD && total_r != 32'hFFFF_FFFF)
        total_r <= total_r + 32'd1;
      if (cmd.define_chrom) chv_r[chx] <= 1'b1;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= opcode_t'(in_opcode);
      ch_r    <= in_chrom_index;
      first_r <= in_first_base;
      last_r  <= in_last_base;
      len_r   <= in_chrom_length;
      bi_r    <= in_bin_index;
      st_r    <= ST_OK;
      pos_r   <= '0;
      cov_r   <= '0;
      norm_r  <= '0;
    end
    if (cmd.st_set) st_r <= cmd.st_code;
    if (cmd.define_chrom) begin
      chlen_r[chx]  <= len_r;
      chbins_r[chx] <= nb_calc[NBW-1:0];
      nb_r          <= nb_calc[NBW-1:0];
      b_r           <= '0;
    end
    if (cmd.clear_step) b_r <= b_r + 1'b1;
    if (cmd.qhi_cap) qhi_r <= quot[31:0];
    if (cmd.walk_init) begin
      b_r      <= quot[BW-1:0];
      bstart_r <= lo - {1'b0, rem};
    end
    if (cmd.walk_wr) begin
      b_r      <= b_r + 1'b1;
      bstart_r <= bstart_r + {1'b0, bs};
    end
    if (cmd.rd_issue) p_r <= 44'(bi_r) * 44'(bs);
    if (cmd.rd_capture) begin
      cov_r <= rdata_r;
      pos_r <= pos_calc;
    end
    if (cmd.norm_mul) prod_r <= 64'(cov_r) * 64'(NORM_MUL);
    if (cmd.norm_raw) norm_r <= {8'd0, cov_r, 8'd0};
    if (cmd.norm_zero) norm_r <= (cov_r != 32'd0) ? MAX48 : 48'd0;
    if (cmd.norm_div) norm_r <= (quot > 64'(MAX48)) ? MAX48 : quot[47:0];
    if (cmd.out_load) begin
      out_status_r <= st_r;
      out_pos_r    <= pos_r;
      out_cov_r    <= cov_r;
      out_norm_r   <= norm_r;
      out_nz_r     <= (cov_r != 32'd0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_position   = out_pos_r;
  assign out_coverage   = out_cov_r;
  assign out_normalized = out_norm_r;
  assign out_nonzero    = out_nz_r;

endmodule

/* hdl/binned_interval_coverage_core.sv */
// Binned interval coverage core, one word in flight at a time.
// Divisions run on a 64-step bit-serial divider. A set sweeps the new chromosome's bins to
// zero, an add does a read-modify-write per spanned bin and a read may add a normalization
// division; rejected words skip these. The next word is taken once the result is loaded.
// Reset clears config, chromosome table and total; bin counters need no pass
// after reset, a chromosome's bins are swept to zero when it is defined.
module binned_interval_coverage_core #(
  parameter int NUM_CHROMS     = bic_pkg::NUM_CHROMS_DEF,
  parameter int BINS_PER_CHROM = bic_pkg::BINS_PER_CHROM_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_opcode,
  input  logic [4:0]                    in_chrom_index,
  input  logic [31:0]                   in_first_base,
  input  logic [31:0]                   in_last_base,
  input  logic [31:0]                   in_chrom_length,
  input  logic [11:0]                   in_bin_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_status,
  output logic [31:0]                   out_position,
  output logic [31:0]                   out_coverage,
  output logic [47:0]                   out_normalized,
  output logic                          out_nonzero,
  input  logic                          cfg_we,
  input  logic [bic_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import bic_pkg::*;

  bic_cmd_t  cmd;
  bic_stat_t stat;

  bic_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bic_datapath #(
    .NUM_CHROMS     (NUM_CHROMS),
    .BINS_PER_CHROM (BINS_PER_CHROM)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_opcode       (in_opcode),
    .in_chrom_index  (in_chrom_index),
    .in_first_base   (in_first_base),
    .in_last_base    (in_last_base),
    .in_chrom_length (in_chrom_length),
    .in_bin_index    (in_bin_index),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_position    (out_position),
    .out_coverage    (out_coverage),
    .out_normalized  (out_normalized),
    .out_nonzero     (out_nonzero)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted word did not hold off input");

  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result posted without returning to idle");

  a_nonzero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_nonzero == (out_coverage != 32'd0)))
    else $error("nonzero flag disagrees with coverage");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_coverage == 32'd0 && out_position == 32'd0)
    else $error("failed word carries data");

endmodule
